// ===== rtl/csqr_pkg.sv =====
// ----------------------------------------------------------------------------
// csqr_pkg: shared definitions for the complex square root unit
// Holds the default data format and the per-item flags that travel down the
// cell chains next to the arithmetic.
// ----------------------------------------------------------------------------
package csqr_pkg;

   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 14;

   // Per-item flags carried alongside the datapath.
   typedef struct packed {
      logic zero;    // both input parts are zero
      logic re_neg;  // input real part is negative
      logic im_neg;  // input imaginary part is negative
   } csqr_flags_type;

endpackage

// ===== rtl/csqr_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// csqr_sqrt_cell: one digit step of an integer square root chain
// Consumes the top two radicand bits, decides one root bit and registers the
// partial root, partial remainder and the item's side data for the next cell.
// ----------------------------------------------------------------------------
module csqr_sqrt_cell #(
   parameter int ROOT_W = 16,
   parameter int SIDE_W = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [2*ROOT_W-1:0]   in_rad,
   input  logic [ROOT_W+1:0]     in_rem,
   input  logic [ROOT_W-1:0]     in_root,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic [2*ROOT_W-1:0]   out_rad,
   output logic [ROOT_W+1:0]     out_rem,
   output logic [ROOT_W-1:0]     out_root,
   output logic [SIDE_W-1:0]     out_side
);

   logic                  valid_ff;
   logic [2*ROOT_W-1:0]   rad_ff, rad_in;
   logic [ROOT_W+1:0]     rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [SIDE_W-1:0]     side_ff;
   logic [ROOT_W+3:0]     rem_sh, trial, diff;
   logic                  ge;

   // Trial subtraction of (4*root + 1) from the shifted remainder.
   assign rem_sh  = {in_rem, in_rad[2*ROOT_W-1 -: 2]};
   assign trial   = {2'b00, in_root, 2'b01};
   assign ge      = (rem_sh >= trial);
   assign diff    = rem_sh - trial;
   assign rem_in  = ge ? diff[ROOT_W+1:0] : rem_sh[ROOT_W+1:0];
   assign root_in = {in_root[ROOT_W-2:0], ge};
   assign rad_in  = {in_rad[2*ROOT_W-3:0], 2'b00};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;

endmodule

// ===== rtl/csqr_div_cell.sv =====
// ----------------------------------------------------------------------------
// csqr_div_cell: one bit step of a restoring division chain
// Brings down one numerator bit, decides one quotient bit and registers the
// partial remainder, partial quotient, divisor and side data.
// ----------------------------------------------------------------------------
module csqr_div_cell #(
   parameter int NUM_W  = 29,
   parameter int DEN_W  = 15,
   parameter int SIDE_W = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [NUM_W-1:0]   in_num,
   input  logic [DEN_W-1:0]   in_rem,
   input  logic [NUM_W-1:0]   in_quo,
   input  logic [DEN_W-1:0]   in_den,
   input  logic [SIDE_W-1:0]  in_side,
   output logic               out_valid,
   output logic [NUM_W-1:0]   out_num,
   output logic [DEN_W-1:0]   out_rem,
   output logic [NUM_W-1:0]   out_quo,
   output logic [DEN_W-1:0]   out_den,
   output logic [SIDE_W-1:0]  out_side
);

   logic               valid_ff;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [NUM_W-1:0]   quo_ff, quo_in;
   logic [DEN_W-1:0]   den_ff;
   logic [SIDE_W-1:0]  side_ff;
   logic [DEN_W:0]     rem_sh, diff;
   logic               ge;

   // The remainder stays below the divisor, so DEN_W bits hold it.
   assign rem_sh = {in_rem, in_num[NUM_W-1]};
   assign ge     = (rem_sh >= {1'b0, in_den});
   assign diff   = rem_sh - {1'b0, in_den};
   assign rem_in = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
   assign quo_in = {in_quo[NUM_W-2:0], ge};
   assign num_in = {in_num[NUM_W-2:0], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         num_ff  <= num_in;
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         den_ff  <= in_den;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_num   = num_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_den   = den_ff;
   assign out_side  = side_ff;

endmodule

// ===== rtl/complex_square_root_unit.sv =====
// ----------------------------------------------------------------------------
// complex_square_root_unit: pipelined principal complex square root
// Returns the principal square root of a signed fixed point complex number,
// branch cut on the negative real axis, through three chains of bit cells.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                               Direction   Beat
//   request   req_valid req_stall req_re_in/im_in  in          one complex input
//   response  rsp_valid rsp_stall rsp_re_out/im_out out        one complex root
//
// One beat enters per cycle while req_stall is low (default format 16/14). The
// three cell chains give one root bit per cell for each square root and one
// quotient bit per cell for the divide.
// Reset is synchronous and active high; it clears the valid bits of every stage.
// The whole pipeline holds while a response beat waits under rsp_stall, and
// req_stall reports exactly that condition.
//
// With a = |re| and b = |im|: m = isqrt(a*a + b*b), k = isqrt((a+m)*2^(F-1)),
// w = floor(b*2^(F-1)/k). A non-negative real part gives (k, +-w), a negative
// one gives (w, +-k), with the imaginary sign taken from the input. Both
// magnitudes saturate to 2^(DATA_WIDTH-1)-1 and a zero input gives zero.
module complex_square_root_unit #(
   parameter int DATA_WIDTH = csqr_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = csqr_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_re_in,
   input  logic signed [DATA_WIDTH-1:0] req_im_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic        [DATA_WIDTH-2:0] rsp_re_out,
   output logic signed [DATA_WIDTH-1:0] rsp_im_out
);

   import csqr_pkg::*;

   localparam int D      = DATA_WIDTH;
   localparam int FLAG_W = $bits(csqr_flags_type);
   // First root: radicand a*a+b*b has 2*D bits, root has D bits.
   localparam int SQ1_W  = D;
   localparam int SIDE1  = FLAG_W + 2 * D;
   // Second root: radicand (a+m)*2^(F-1) has D+F bits.
   localparam int X_W    = D + FRAC_BITS;
   localparam int SQ2_W  = (X_W + 1) / 2;
   localparam int SIDE2  = FLAG_W + D;
   // Divide: numerator b*2^(F-1).
   localparam int DIV_W  = D + FRAC_BITS - 1;
   localparam int WIDE_W = (DIV_W > SQ2_W) ? DIV_W : SQ2_W;

   // The pipeline moves whenever the response register can take a beat.
   logic advance;
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // Input stage: magnitudes and signs.
   logic                valid_a_ff;
   logic [D-1:0]        a_ff, b_ff;
   csqr_flags_type      flags_a_ff, flags_a_in;
   logic [D-1:0]        a_in, b_in;

   assign a_in = req_re_in[D-1] ? (~req_re_in + 1'b1) : req_re_in;
   assign b_in = req_im_in[D-1] ? (~req_im_in + 1'b1) : req_im_in;
   always_comb begin
      flags_a_in.zero   = (req_re_in == '0) && (req_im_in == '0);
      flags_a_in.re_neg = req_re_in[D-1];
      flags_a_in.im_neg = req_im_in[D-1];
   end

   // Square-sum stage.
   logic                valid_b_ff;
   logic [2*D-1:0]      sum_ff, sum_in;
   logic [D-1:0]        a_b_ff, b_b_ff;
   csqr_flags_type      flags_b_ff;

   assign sum_in = ({{D{1'b0}}, a_ff} * {{D{1'b0}}, a_ff})
                 + ({{D{1'b0}}, b_ff} * {{D{1'b0}}, b_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else if (advance) begin
         valid_a_ff <= req_valid;
         valid_b_ff <= valid_a_ff;
      end
      if (advance) begin
         a_ff       <= a_in;
         b_ff       <= b_in;
         flags_a_ff <= flags_a_in;
         sum_ff     <= sum_in;
         a_b_ff     <= a_ff;
         b_b_ff     <= b_ff;
         flags_b_ff <= flags_a_ff;
      end
   end

   // First square root chain: m = isqrt(a*a + b*b).
   logic                 s1_valid [0:SQ1_W];
   logic [2*SQ1_W-1:0]   s1_rad   [0:SQ1_W];
   logic [SQ1_W+1:0]     s1_rem   [0:SQ1_W];
   logic [SQ1_W-1:0]     s1_root  [0:SQ1_W];
   logic [SIDE1-1:0]     s1_side  [0:SQ1_W];

   assign s1_valid[0] = valid_b_ff;
   assign s1_rad[0]   = sum_ff;
   assign s1_rem[0]   = '0;
   assign s1_root[0]  = '0;
   assign s1_side[0]  = {flags_b_ff, a_b_ff, b_b_ff};

   for (genvar i = 0; i < SQ1_W; i++) begin : g_sq1
      csqr_sqrt_cell #(.ROOT_W(SQ1_W), .SIDE_W(SIDE1)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (advance),
         .in_valid  (s1_valid[i]),
         .in_rad    (s1_rad[i]),
         .in_rem    (s1_rem[i]),
         .in_root   (s1_root[i]),
         .in_side   (s1_side[i]),
         .out_valid (s1_valid[i+1]),
         .out_rad   (s1_rad[i+1]),
         .out_rem   (s1_rem[i+1]),
         .out_root  (s1_root[i+1]),
         .out_side  (s1_side[i+1])
      );
   end

   // Scaled sum stage: x = (a + m) * 2^(F-1).
   logic                valid_c_ff;
   logic [X_W-1:0]      x_ff, x_in;
   logic [SIDE2-1:0]    side_c_ff;
   logic [D-1:0]        a_s1, b_s1;
   logic [FLAG_W-1:0]   flags_s1;
   logic [D:0]          am_sum;

   assign {flags_s1, a_s1, b_s1} = s1_side[SQ1_W];
   assign am_sum = {1'b0, a_s1} + {1'b0, s1_root[SQ1_W]};
   assign x_in   = {am_sum, {(FRAC_BITS-1){1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_c_ff <= 1'b0;
      end else if (advance) begin
         valid_c_ff <= s1_valid[SQ1_W];
      end
      if (advance) begin
         x_ff      <= x_in;
         side_c_ff <= {flags_s1, b_s1};
      end
   end

   // Second square root chain: k = isqrt(x).
   logic                 s2_valid [0:SQ2_W];
   logic [2*SQ2_W-1:0]   s2_rad   [0:SQ2_W];
   logic [SQ2_W+1:0]     s2_rem   [0:SQ2_W];
   logic [SQ2_W-1:0]     s2_root  [0:SQ2_W];
   logic [SIDE2-1:0]     s2_side  [0:SQ2_W];

   assign s2_valid[0] = valid_c_ff;
   assign s2_rad[0]   = (2*SQ2_W)'(x_ff);
   assign s2_rem[0]   = '0;
   assign s2_root[0]  = '0;
   assign s2_side[0]  = side_c_ff;

   for (genvar i = 0; i < SQ2_W; i++) begin : g_sq2
      csqr_sqrt_cell #(.ROOT_W(SQ2_W), .SIDE_W(SIDE2)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (advance),
         .in_valid  (s2_valid[i]),
         .in_rad    (s2_rad[i]),
         .in_rem    (s2_rem[i]),
         .in_root   (s2_root[i]),
         .in_side   (s2_side[i]),
         .out_valid (s2_valid[i+1]),
         .out_rad   (s2_rad[i+1]),
         .out_rem   (s2_rem[i+1]),
         .out_root  (s2_root[i+1]),
         .out_side  (s2_side[i+1])
      );
   end

   // Divide chain: w = floor(b * 2^(F-1) / k). A zero k only comes with a zero
   // input, whose result is forced to zero at the end.
   logic [D-1:0]         b_s2;
   logic [FLAG_W-1:0]    flags_s2;
   logic                 dv_valid [0:DIV_W];
   logic [DIV_W-1:0]     dv_num   [0:DIV_W];
   logic [SQ2_W-1:0]     dv_rem   [0:DIV_W];
   logic [DIV_W-1:0]     dv_quo   [0:DIV_W];
   logic [SQ2_W-1:0]     dv_den   [0:DIV_W];
   logic [FLAG_W-1:0]    dv_side  [0:DIV_W];

   assign {flags_s2, b_s2} = s2_side[SQ2_W];
   assign dv_valid[0] = s2_valid[SQ2_W];
   assign dv_num[0]   = {b_s2, {(FRAC_BITS-1){1'b0}}};
   assign dv_rem[0]   = '0;
   assign dv_quo[0]   = '0;
   assign dv_den[0]   = s2_root[SQ2_W];
   assign dv_side[0]  = flags_s2;

   for (genvar i = 0; i < DIV_W; i++) begin : g_div
      csqr_div_cell #(.NUM_W(DIV_W), .DEN_W(SQ2_W), .SIDE_W(FLAG_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (advance),
         .in_valid  (dv_valid[i]),
         .in_num    (dv_num[i]),
         .in_rem    (dv_rem[i]),
         .in_quo    (dv_quo[i]),
         .in_den    (dv_den[i]),
         .in_side   (dv_side[i]),
         .out_valid (dv_valid[i+1]),
         .out_num   (dv_num[i+1]),
         .out_rem   (dv_rem[i+1]),
         .out_quo   (dv_quo[i+1]),
         .out_den   (dv_den[i+1]),
         .out_side  (dv_side[i+1])
      );
   end

   // Output stage: saturate, pick the quadrant and apply the imaginary sign.
   csqr_flags_type       flags_d;
   logic [WIDE_W-1:0]    k_wide, w_wide, mag_max;
   logic [D-2:0]         k_sat, w_sat, re_mag, im_mag;
   logic [D-2:0]         re_out_in;
   logic [D-1:0]         im_out_in;
   logic                 rsp_valid_ff;
   logic [D-2:0]         re_out_ff;
   logic [D-1:0]         im_out_ff;

   assign flags_d = dv_side[DIV_W];
   assign k_wide  = WIDE_W'(dv_den[DIV_W]);
   assign w_wide  = WIDE_W'(dv_quo[DIV_W]);
   assign mag_max = WIDE_W'({(D-1){1'b1}});
   assign k_sat   = (k_wide > mag_max) ? {(D-1){1'b1}} : k_wide[D-2:0];
   assign w_sat   = (w_wide > mag_max) ? {(D-1){1'b1}} : w_wide[D-2:0];

   always_comb begin
      if (flags_d.re_neg) begin
         re_mag = w_sat;
         im_mag = k_sat;
      end else begin
         re_mag = k_sat;
         im_mag = w_sat;
      end
      if (flags_d.zero) begin
         re_out_in = '0;
         im_out_in = '0;
      end else begin
         re_out_in = re_mag;
         im_out_in = flags_d.im_neg ? (~{1'b0, im_mag} + 1'b1) : {1'b0, im_mag};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid[DIV_W];
      end
      if (advance) begin
         re_out_ff <= re_out_in;
         im_out_ff <= im_out_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_re_out = re_out_ff;
   assign rsp_im_out = im_out_ff;

   // A finished beat in the last cell reaches the response register.
   a_last_moves: assert property (@(posedge clock) disable iff (reset)
      advance && dv_valid[DIV_W] |=> rsp_valid_ff)
      else $error("finished beat lost before the response register");

   // A taken response with nothing behind it leaves the register empty.
   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall && !dv_valid[DIV_W] |=> !rsp_valid_ff)
      else $error("response beat repeated");

   // A zero input leaves as a zero root.
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      advance && dv_valid[DIV_W] && flags_d.zero |=>
         (rsp_re_out == '0) && (rsp_im_out == '0))
      else $error("zero input gave a nonzero root");

   // Saturation keeps the imaginary part off the most negative code.
   a_im_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_im_out != {1'b1, {(D-1){1'b0}}}))
      else $error("imaginary part reached the most negative code");

endmodule
